>>> hdl/tte_pkg.sv
`timescale 1ns / 1ps

package tte_pkg;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 24;
  localparam int DELAY_BITS     = 16;
  localparam int GAIN_BITS      = 16;
  localparam int COEF_BITS      = 24;

  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP1_DELAY    = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TAP2_DELAY    = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_B0       = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_B1       = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_B2       = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_A1       = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_A2       = 3'd7;

  // Controller to datapath commands, one step of the item sequence each.
  typedef struct packed {
    logic clear;    // write zero at the pointer and advance it
    logic load_in;  // capture the input sample
    logic rd1;      // read first tap
    logic rd2;      // read second tap, capture first tap
    logic mul_t;    // second tap times b0 and b1
    logic y_calc;   // form filter output, second tap times b2
    logic mul_y;    // filter output times a1 and a2
    logic upd;      // update filter state, filter output times gain
    logic wb;       // write slot back, advance pointer, load result
  } cmd_t;

  typedef struct packed {
    logic clear_last;  // pointer sits on the last slot
    logic cfg_busy;    // tap delay reduction still running
  } status_t;

endpackage

>>> hdl/tte_dmod.sv
`timescale 1ns / 1ps

module tte_dmod #(
  parameter int DEPTH = 32768
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load1,
  input  logic                            load2,
  input  logic [tte_pkg::DELAY_BITS-1:0]  value,
  output logic [tte_pkg::DELAY_BITS-1:0]  d1,
  output logic [tte_pkg::DELAY_BITS-1:0]  d2,
  output logic                            busy
);

  localparam int AW = $clog2(DEPTH);
  localparam int SH = tte_pkg::DELAY_BITS + AW;
  localparam int RW = tte_pkg::DELAY_BITS + 2;
  localparam int PW = tte_pkg::DELAY_BITS + RW;
  // ceil(2^SH / DEPTH) gives the exact quotient for every delay value.
  localparam longint RECIP =
    ((64'sd1 <<< SH) + longint'(DEPTH) - 64'sd1) / longint'(DEPTH);
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [tte_pkg::DELAY_BITS-1:0] DEPTH_LO = tte_pkg::DELAY_BITS'(DEPTH);

  logic                            phase;
  logic [PW-1:0]                   prod1;
  logic [PW-1:0]                   prod2;
  logic [tte_pkg::DELAY_BITS-1:0]  q1;
  logic [tte_pkg::DELAY_BITS-1:0]  q2;

  // Reciprocal multiplication: the quotient is registered first, then the remainder is formed from it.
  assign prod1 = PW'(d1) * PW'(RECIP_V);
  assign prod2 = PW'(d2) * PW'(RECIP_V);

  always_ff @(posedge clk) begin
    if (rst) begin
      d1    <= tte_pkg::DELAY_BITS'(1);
      d2    <= tte_pkg::DELAY_BITS'(1);
      busy  <= 1'b0;
      phase <= 1'b0;
      q1    <= '0;
      q2    <= '0;
    end else if (load1 || load2) begin
      if (load1) begin
        d1 <= value;
      end
      if (load2) begin
        d2 <= value;
      end
      busy  <= 1'b1;
      phase <= 1'b0;
    end else if (busy) begin
      if (!phase) begin
        q1    <= tte_pkg::DELAY_BITS'(prod1 >> SH);
        q2    <= tte_pkg::DELAY_BITS'(prod2 >> SH);
        phase <= 1'b1;
      end else begin
        d1    <= d1 - q1 * DEPTH_LO;
        d2    <= d2 - q2 * DEPTH_LO;
        busy  <= 1'b0;
        phase <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/tte_ctrl.sv
`timescale 1ns / 1ps

module tte_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  tte_pkg::status_t  status,
  output tte_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_MULT  = 4'd4;
  localparam logic [3:0] S_YCALC = 4'd5;
  localparam logic [3:0] S_MULY  = 4'd6;
  localparam logic [3:0] S_UPD   = 4'd7;
  localparam logic [3:0] S_WB    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_free;
  logic       accept;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == S_IDLE || (state == S_WB && out_free)) && !status.cfg_busy);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd         = '0;
    cmd.clear   = (state == S_CLEAR);
    cmd.load_in = accept;
    cmd.rd1     = (state == S_RD1);
    cmd.rd2     = (state == S_RD2);
    cmd.mul_t   = (state == S_MULT);
    cmd.y_calc  = (state == S_YCALC);
    cmd.mul_y   = (state == S_MULY);
    cmd.upd     = (state == S_UPD);
    cmd.wb      = (state == S_WB) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (status.clear_last) state_next = S_IDLE;
      S_IDLE:  if (accept) state_next = S_RD1;
      S_RD1:   state_next = S_RD2;
      S_RD2:   state_next = S_MULT;
      S_MULT:  state_next = S_YCALC;
      S_YCALC: state_next = S_MULY;
      S_MULY:  state_next = S_UPD;
      S_UPD:   state_next = S_WB;
      S_WB: begin
        if (out_free) begin
          state_next = accept ? S_RD1 : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.wb) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/tte_dp.sv
`timescale 1ns / 1ps

module tte_dp #(
  parameter int DEPTH       = 32768,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  tte_pkg::cmd_t                       cmd,
  output tte_pkg::status_t                    status,
  input  logic                                cfg_we,
  input  logic [tte_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic signed [SAMPLE_BITS-1:0]       tap1_sample,
  output logic signed [SAMPLE_BITS-1:0]       tap2_sample
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = ((AW > tte_pkg::DELAY_BITS) ? AW : tte_pkg::DELAY_BITS) + 1;
  localparam logic signed [41:0] SMAX = (42'sd1 <<< (SAMPLE_BITS - 1)) - 42'sd1;
  localparam logic signed [41:0] SMIN = -SMAX - 42'sd1;
  localparam logic signed [56:0] RND20 = 57'sd524288;
  localparam logic signed [56:0] RND15 = 57'sd16384;

  function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -38'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  // Configuration
  logic                                 dmod_busy;
  logic [tte_pkg::DELAY_BITS-1:0]       d1;
  logic [tte_pkg::DELAY_BITS-1:0]       d2;
  logic [tte_pkg::GAIN_BITS-1:0]        gain;
  logic signed [tte_pkg::COEF_BITS-1:0] b0, b1, b2, a1, a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= '0;
      b0   <= tte_pkg::COEF_BITS'(1048576);
      b1   <= '0;
      b2   <= '0;
      a1   <= '0;
      a2   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tte_pkg::REG_FEEDBACK_GAIN: gain <= cfg_data[tte_pkg::GAIN_BITS-1:0];
        tte_pkg::REG_COEF_B0:       b0   <= signed'(cfg_data);
        tte_pkg::REG_COEF_B1:       b1   <= signed'(cfg_data);
        tte_pkg::REG_COEF_B2:       b2   <= signed'(cfg_data);
        tte_pkg::REG_COEF_A1:       a1   <= signed'(cfg_data);
        tte_pkg::REG_COEF_A2:       a2   <= signed'(cfg_data);
        default: ;
      endcase
    end
  end

  tte_dmod #(
    .DEPTH(DEPTH)
  ) u_dmod (
    .clk   (clk),
    .rst   (rst),
    .load1 (cfg_we && cfg_index == tte_pkg::REG_TAP1_DELAY),
    .load2 (cfg_we && cfg_index == tte_pkg::REG_TAP2_DELAY),
    .value (cfg_data[tte_pkg::DELAY_BITS-1:0]),
    .d1    (d1),
    .d2    (d2),
    .busy  (dmod_busy)
  );

  // Pointer, tap addresses, delay line
  logic [AW-1:0]          wp;
  logic [AW-1:0]          wp_next;
  logic [IW-1:0]          diff1, diff2;
  logic [AW-1:0]          idx1, idx2, raddr;
  logic [SAMPLE_BITS-1:0] mem [DEPTH];
  logic [SAMPLE_BITS-1:0] rd;
  logic                   mem_we;
  logic [SAMPLE_BITS-1:0] mem_wdata;
  logic signed [SAMPLE_BITS-1:0] slot;

  assign wp_next = (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
  assign status.clear_last = (wp == AW'(DEPTH - 1));
  assign status.cfg_busy   = dmod_busy;

  always_comb begin
    diff1 = IW'(wp) - IW'(d1);
    if (diff1[IW-1]) begin
      diff1 = diff1 + IW'(DEPTH);
    end
    diff2 = IW'(wp) - IW'(d2);
    if (diff2[IW-1]) begin
      diff2 = diff2 + IW'(DEPTH);
    end
    idx1  = diff1[AW-1:0];
    idx2  = diff2[AW-1:0];
    raddr = cmd.rd2 ? idx2 : idx1;
  end

  assign mem_we    = cmd.clear || cmd.wb;
  assign mem_wdata = cmd.clear ? '0 : slot;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= mem_wdata;
    end
    rd <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
    end else if (cmd.clear || cmd.wb) begin
      wp <= wp_next;
    end
  end

  // Taps and biquad
  logic signed [SAMPLE_BITS-1:0] x, t1, t2, t2r;
  logic                          byp1, byp2;
  logic signed [31:0]            ma0, ma1;
  logic signed [23:0]            mb0, mb1;
  logic signed [55:0]            prod0, prod1;
  logic signed [55:0]            pb0, pb1, pb2, pa1, pa2, pg;
  logic signed [31:0]            y, z1, z2;
  logic signed [31:0]            y_next, z1_next, z2_next;
  logic signed [56:0]            sh_y, sh_z1, sh_z2, sh_fb;
  logic signed [41:0]            sum_fb;

  // A zero delay after reduction returns the input sample, not a delay-line read.
  assign t2 = byp2 ? x : signed'(rd);

  always_comb begin
    ma0 = 32'(t2);
    mb0 = b0;
    ma1 = 32'(t2);
    mb1 = b1;
    if (cmd.y_calc) begin
      ma0 = 32'(t2r);
      mb0 = b2;
    end
    if (cmd.mul_y) begin
      ma0 = y;
      mb0 = a1;
      ma1 = y;
      mb1 = a2;
    end
    if (cmd.upd) begin
      ma0 = y;
      mb0 = signed'({8'h00, gain});
    end
  end

  assign prod0 = ma0 * mb0;
  assign prod1 = ma1 * mb1;

  always_comb begin
    sh_y    = (57'(pb0) + RND20) >>> 20;
    y_next  = sat32(38'(sh_y) + 38'(z1));
    sh_z1   = (57'(pb1) - 57'(pa1) + RND20) >>> 20;
    z1_next = sat32(38'(sh_z1) + 38'(z2));
    sh_z2   = (57'(pb2) - 57'(pa2) + RND20) >>> 20;
    z2_next = sat32(38'(sh_z2));
    sh_fb   = (57'(pg) + RND15) >>> 15;
    sum_fb  = 42'(sh_fb) + 42'(x);
    if (sum_fb > SMAX) begin
      slot = SAMPLE_BITS'(SMAX);
    end else if (sum_fb < SMIN) begin
      slot = SAMPLE_BITS'(SMIN);
    end else begin
      slot = SAMPLE_BITS'(sum_fb);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      z1 <= '0;
      z2 <= '0;
    end else if (cmd.upd) begin
      z1 <= z1_next;
      z2 <= z2_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= in_sample;
    end
    if (cmd.rd1) begin
      byp1 <= (d1 == '0);
    end
    if (cmd.rd2) begin
      t1   <= byp1 ? x : signed'(rd);
      byp2 <= (d2 == '0);
    end
    if (cmd.mul_t) begin
      t2r <= t2;
      pb0 <= prod0;
      pb1 <= prod1;
    end
    if (cmd.y_calc) begin
      y   <= y_next;
      pb2 <= prod0;
    end
    if (cmd.mul_y) begin
      pa1 <= prod0;
      pa2 <= prod1;
    end
    if (cmd.upd) begin
      pg <= prod0;
    end
    if (cmd.wb) begin
      tap1_sample <= t1;
      tap2_sample <= t2r;
    end
  end

endmodule

>>> hdl/two_tap_feedback_echo.sv
`timescale 1ns / 1ps

// Two-tap feedback echo. Each input transaction carries one signed mono
// sample; it goes into a circular delay line of DEPTH slots, two taps are
// read tap1_delay and tap2_delay slots behind it (a delay that is a multiple
// of DEPTH returns the input itself), and the second tap is damped by a
// transposed direct form II biquad, scaled by feedback_gain (Q1.15) and
// added into the new slot with saturation. One output transaction carries
// both taps. An accepted item steps through S_RD1, S_RD2, S_MULT, S_YCALC,
// S_MULY, S_UPD and S_WB, which loads its result into the output register;
// the next item is accepted in the cycle its predecessor writes back. The
// sequence length is set by the single read port of the delay line (two tap
// reads) and the two multipliers the biquad and gain share over four steps.
// The output register holds a finished result while the next item runs; a
// result still held at write-back time holds the sequence until it is taken.
// After reset a clearing pass zeroes all DEPTH slots of the delay line,
// during which in_stall stays high (configuration writes are still taken).
// Writing a tap delay starts a reduction mod DEPTH that also holds in_stall.
// Write configuration only while no transaction is in flight.
module two_tap_feedback_echo #(
  parameter int DEPTH       = 32768,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tte_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tte_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SAMPLE_BITS-1:0]       tap1_sample,
  output logic signed [SAMPLE_BITS-1:0]       tap2_sample
);

  tte_pkg::cmd_t    cmd;
  tte_pkg::status_t status;

  // Sequence the steps of one item, own the handshakes.
  tte_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Delay line, tap addressing, biquad and feedback arithmetic.
  tte_dp #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample   (in_sample),
    .tap1_sample (tap1_sample),
    .tap2_sample (tap2_sample)
  );

  // Never overwrite a result that is still held downstream.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.wb |-> !(out_valid && out_stall))
    else $error("result register overwritten while held");

  // Take no transaction while tap delays are still being reduced.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !status.cfg_busy)
    else $error("transaction taken during delay reduction");

  // Take no transaction during the clearing pass.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !cmd.clear)
    else $error("transaction taken during clearing pass");

  // The two tap reads run back to back.
  a_tap_reads: assert property (@(posedge clk) disable iff (rst)
    cmd.rd1 |=> cmd.rd2)
    else $error("second tap read did not follow the first");

endmodule
